@@ hw/rtl/rpc_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rpc_pkg
// Shared widths and defaults for the route cost evaluator.
// -----------------------------------------------------------------------------
package rpc_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int COORD_W       = 16;
   localparam int DEMAND_W      = 16;
   localparam int MONEY_W       = 32;
   localparam int RISK_W        = 56;
   localparam int COST_W        = 48;
   localparam int PEN_W         = 25;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 56;
   localparam int SUMSQ_W       = 33;

   localparam logic [CSR_IDX_W-1:0] CSR_RISK_THRESHOLD   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY_DISTANCE = 1'd1;

endpackage

@@ hw/rtl/risk_penalized_route_cost_top.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// risk_penalized_route_cost_top
// Tour cost evaluator with per-route risk penalties.
// -----------------------------------------------------------------------------
// Usage:
//   Stops of a tour enter on the req_ channel in visiting order. Each request
//   carries coordinates relative to the depot, demand and route flags. The
//   block adds Euclidean leg lengths to the cost, tracks carried money and
//   risk per route, and charges money times penalty_distance whenever risk
//   exceeds risk_threshold. A request with last_stop set produces one rsp_
//   item with the total cost and a penalty flag; other requests produce none.
//   Sequence: each leg root takes two multiplies for the squared distance,
//   a start state and the 17+FRAC_BITS step bit-serial root; risk and
//   penalty updates (multiply, add, multiply, add) follow each leg. A request
//   runs one root for a route start or a stop after a held stop, two roots
//   when a held stop's leg and a depot leg both fall on the request. The
//   single multiplier and the bit-serial root unit set how long a request
//   takes; req_stall stays high until the request is finished.
//   A result waits in an output register; while rsp_stall holds it, the block
//   keeps accepting requests and only blocks at the next last stop.
//   Reset (synchronous) clears control, CSR and tour state; a fresh tour starts.
//   csr_ writes apply at once; make them only while idle.
// -----------------------------------------------------------------------------
module risk_penalized_route_cost_top #(
   parameter int FRAC_BITS = rpc_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rpc_pkg::COORD_W-1:0]  req_stop_x,
   input  logic signed [rpc_pkg::COORD_W-1:0]  req_stop_y,
   input  logic [rpc_pkg::DEMAND_W-1:0]        req_stop_demand,
   input  logic                                req_returns_to_depot,
   input  logic                                req_last_stop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rpc_pkg::COST_W-1:0]          rsp_total_cost,
   output logic                                rsp_any_penalty,
   input  logic                                csr_we,
   input  logic [rpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rpc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int DIST_W = 17 + FRAC_BITS;
   localparam int MB_W   = (DIST_W > rpc_pkg::PEN_W) ? DIST_W : rpc_pkg::PEN_W;
   localparam int PW     = rpc_pkg::MONEY_W + MB_W;
   localparam int CW     = rpc_pkg::COORD_W;
   localparam int MW     = rpc_pkg::MONEY_W;
   localparam int RKW    = rpc_pkg::RISK_W;
   localparam int CSTW   = rpc_pkg::COST_W;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_SQX        = 4'd1;
   localparam logic [3:0] S_SQY        = 4'd2;
   localparam logic [3:0] S_ROOT_GO    = 4'd3;
   localparam logic [3:0] S_ROOT_WAIT  = 4'd4;
   localparam logic [3:0] S_HOME_APPLY = 4'd5;
   localparam logic [3:0] S_RISK_MUL   = 4'd6;
   localparam logic [3:0] S_RISK_ADD   = 4'd7;
   localparam logic [3:0] S_PEN_MUL    = 4'd8;
   localparam logic [3:0] S_PEN_ADD    = 4'd9;
   localparam logic [3:0] S_ROUTE      = 4'd10;
   localparam logic [3:0] S_FINISH     = 4'd11;

   localparam logic PH_LEG  = 1'b0;   // leg from held stop to this stop
   localparam logic PH_HOME = 1'b1;   // depot legs of this stop

   // configuration
   logic [RKW-1:0]             thr_ff;
   logic [rpc_pkg::PEN_W-1:0]  pen_ff;

   // sequencer and latched request
   logic [3:0]         state_ff, state_in;
   logic               phase_ff, phase_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic [rpc_pkg::DEMAND_W-1:0] dem_ff, dem_in;
   logic               ret_ff, ret_in, last_ff, last_in;

   // tour state
   logic signed [CW-1:0] hx_ff, hx_in, hy_ff, hy_in;
   logic [rpc_pkg::DEMAND_W-1:0] hdem_ff, hdem_in;
   logic               pend_ff, pend_in;
   logic               rsn_ff, rsn_in;
   logic [MW-1:0]      money_ff, money_in;
   logic [RKW-1:0]     risk_ff, risk_in;
   logic [CSTW-1:0]    cost_ff, cost_in;
   logic               seen_ff, seen_in;

   // datapath
   logic [31:0]        sqx_ff, sqx_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;

   // result register
   logic               rv_ff, rv_in;
   logic [CSTW-1:0]    rcost_ff, rcost_in;
   logic               rpen_ff, rpen_in;

   logic               req_accept;
   logic               out_free;
   logic signed [CW:0] dx, dy;
   logic [CW-1:0]      ax, ay;
   logic [MW-1:0]      mul_a;
   logic [MB_W-1:0]    mul_b;
   logic [PW-1:0]      mul_p;
   logic               root_go;
   logic               root_done;
   logic [DIST_W-1:0]  root;
   logic [rpc_pkg::SUMSQ_W-1:0] sumsq;

   logic [RKW-1:0]     risk_term;
   logic [RKW:0]       risk_sum;
   logic [CSTW-1:0]    pen_term;
   logic [CSTW:0]      cost_pen_sum;
   logic [CSTW:0]      cost_dist_sum;
   logic [MW:0]        money_sum;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign out_free   = !rv_ff || !rsp_stall;

   // leg deltas: held stop to this stop, or depot to this stop
   always_comb begin
      if (phase_ff == PH_LEG) begin
         dx = (CW+1)'(hx_ff) - (CW+1)'(x_ff);
         dy = (CW+1)'(hy_ff) - (CW+1)'(y_ff);
      end else begin
         dx = (CW+1)'(x_ff);
         dy = (CW+1)'(y_ff);
      end
   end

   assign ax = dx[CW] ? CW'(-dx) : dx[CW-1:0];
   assign ay = dy[CW] ? CW'(-dy) : dy[CW-1:0];

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_SQX: begin
            mul_a = MW'(ax);
            mul_b = MB_W'(ax);
         end
         S_SQY: begin
            mul_a = MW'(ay);
            mul_b = MB_W'(ay);
         end
         S_PEN_MUL: begin
            mul_a = money_ff;
            mul_b = MB_W'(pen_ff);
         end
         default: begin
            mul_a = money_ff;
            mul_b = MB_W'(dist_ff);
         end
      endcase
   end

   rpc_mul #(
      .A_W (MW),
      .B_W (MB_W)
   ) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign sumsq   = rpc_pkg::SUMSQ_W'(sqx_ff) + rpc_pkg::SUMSQ_W'(mul_p[31:0]);
   assign root_go = (state_ff == S_ROOT_GO);

   rpc_sqrt #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_go),
      .radicand (sumsq),
      .done     (root_done),
      .root     (root)
   );

   // saturating arithmetic
   assign risk_term     = (|mul_p[PW-1:RKW]) ? {RKW{1'b1}} : mul_p[RKW-1:0];
   assign risk_sum      = {1'b0, risk_ff} + {1'b0, risk_term};
   assign pen_term      = (|mul_p[PW-1:CSTW]) ? {CSTW{1'b1}} : mul_p[CSTW-1:0];
   assign cost_pen_sum  = {1'b0, cost_ff} + {1'b0, pen_term};
   assign cost_dist_sum = {1'b0, cost_ff} + (CSTW+1)'(dist_ff);
   assign money_sum     = {1'b0, money_ff} + (MW+1)'(hdem_ff);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      dem_in   = dem_ff;
      ret_in   = ret_ff;
      last_in  = last_ff;
      hx_in    = hx_ff;
      hy_in    = hy_ff;
      hdem_in  = hdem_ff;
      pend_in  = pend_ff;
      rsn_in   = rsn_ff;
      money_in = money_ff;
      risk_in  = risk_ff;
      cost_in  = cost_ff;
      seen_in  = seen_ff;
      sqx_in   = sqx_ff;
      dist_in  = dist_ff;
      rv_in    = rv_ff && rsp_stall;
      rcost_in = rcost_ff;
      rpen_in  = rpen_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               x_in    = req_stop_x;
               y_in    = req_stop_y;
               dem_in  = req_stop_demand;
               ret_in  = req_returns_to_depot || req_last_stop;
               last_in = req_last_stop;
               if (pend_ff) begin
                  phase_in = PH_LEG;
                  state_in = S_SQX;
               end else begin
                  state_in = S_ROUTE;
               end
            end
         end
         S_SQX: state_in = S_SQY;
         S_SQY: begin
            sqx_in   = mul_p[31:0];
            state_in = S_ROOT_GO;
         end
         S_ROOT_GO: state_in = S_ROOT_WAIT;
         S_ROOT_WAIT: begin
            if (root_done) begin
               dist_in  = root;
               state_in = (phase_ff == PH_LEG) ? S_RISK_MUL : S_HOME_APPLY;
            end
         end
         S_HOME_APPLY: begin
            if (rsn_ff) begin
               risk_in  = '0;
               money_in = MW'(dem_ff);
               rsn_in   = 1'b0;
               cost_in  = cost_dist_sum[CSTW] ? {CSTW{1'b1}} : cost_dist_sum[CSTW-1:0];
            end
            state_in = ret_ff ? S_RISK_MUL : S_FINISH;
         end
         S_RISK_MUL: state_in = S_RISK_ADD;
         S_RISK_ADD: begin
            cost_in = cost_dist_sum[CSTW] ? {CSTW{1'b1}} : cost_dist_sum[CSTW-1:0];
            risk_in = risk_sum[RKW] ? {RKW{1'b1}} : risk_sum[RKW-1:0];
            if (phase_ff == PH_LEG) begin
               money_in = money_sum[MW] ? {MW{1'b1}} : money_sum[MW-1:0];
            end
            state_in = S_PEN_MUL;
         end
         S_PEN_MUL: state_in = S_PEN_ADD;
         S_PEN_ADD: begin
            if (risk_ff > thr_ff) begin
               cost_in = cost_pen_sum[CSTW] ? {CSTW{1'b1}} : cost_pen_sum[CSTW-1:0];
               seen_in = 1'b1;
            end
            if (phase_ff == PH_LEG) begin
               pend_in  = 1'b0;
               state_in = S_ROUTE;
            end else begin
               rsn_in   = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_ROUTE: begin
            if (rsn_ff || ret_ff) begin
               phase_in = PH_HOME;
               state_in = S_SQX;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!ret_ff) begin
               hx_in    = x_ff;
               hy_in    = y_ff;
               hdem_in  = dem_ff;
               pend_in  = 1'b1;
               state_in = S_IDLE;
            end else if (!last_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rv_in    = 1'b1;
               rcost_in = cost_ff;
               rpen_in  = seen_ff;
               cost_in  = '0;
               seen_in  = 1'b0;
               pend_in  = 1'b0;
               rsn_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         thr_ff   <= '0;
         pen_ff   <= '0;
         hx_ff    <= '0;
         hy_ff    <= '0;
         hdem_ff  <= '0;
         pend_ff  <= 1'b0;
         rsn_ff   <= 1'b1;
         money_ff <= '0;
         risk_ff  <= '0;
         cost_ff  <= '0;
         seen_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == rpc_pkg::CSR_RISK_THRESHOLD) begin
            thr_ff <= csr_wdata[RKW-1:0];
         end
         if (csr_we && csr_index == rpc_pkg::CSR_PENALTY_DISTANCE) begin
            pen_ff <= csr_wdata[rpc_pkg::PEN_W-1:0];
         end
         hx_ff    <= hx_in;
         hy_ff    <= hy_in;
         hdem_ff  <= hdem_in;
         pend_ff  <= pend_in;
         rsn_ff   <= rsn_in;
         money_ff <= money_in;
         risk_ff  <= risk_in;
         cost_ff  <= cost_in;
         seen_ff  <= seen_in;
         rv_ff    <= rv_in;
      end
      phase_ff <= phase_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      dem_ff   <= dem_in;
      ret_ff   <= ret_in;
      last_ff  <= last_in;
      sqx_ff   <= sqx_in;
      dist_ff  <= dist_in;
      rcost_ff <= rcost_in;
      rpen_ff  <= rpen_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_total_cost  = rcost_ff;
   assign rsp_any_penalty = rpen_ff;

   // no new request while a stop is in progress
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request path open while busy");

   // an accepted request always starts the sequencer
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("accepted request did not start work");

   // root results only arrive while the sequencer waits for them
   a_root_expected: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == S_ROOT_WAIT))
      else $error("unexpected root completion");

endmodule

@@ hw/rtl/rpc_mul.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rpc_mul
// Shared unsigned multiplier with registered product.
// -----------------------------------------------------------------------------
module rpc_mul #(
   parameter int A_W = 32,
   parameter int B_W = 25
) (
   input  logic                 clock,
   input  logic [A_W-1:0]       mul_a,
   input  logic [B_W-1:0]       mul_b,
   output logic [A_W+B_W-1:0]   mul_p
);

   logic [A_W+B_W-1:0] prod_ff;
   logic [A_W+B_W-1:0] prod_in;

   assign prod_in = {{B_W{1'b0}}, mul_a} * {{A_W{1'b0}}, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

@@ hw/rtl/rpc_sqrt.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rpc_sqrt
// Digit-by-digit square root, one result bit per cycle.
// -----------------------------------------------------------------------------
module rpc_sqrt #(
   parameter int FRAC_BITS = rpc_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rpc_pkg::SUMSQ_W-1:0]       radicand,
   output logic                              done,
   output logic [17+FRAC_BITS-1:0]           root
);

   localparam int P   = 17 + FRAC_BITS;   // result bits / radicand pairs
   localparam int RW  = P + 3;
   localparam int CW  = $clog2(P);

   logic [2*P-1:0] rad_ff,  rad_in;
   logic [RW-1:0]  rem_ff,  rem_in;
   logic [P-1:0]   root_ff, root_in;
   logic [CW-1:0]  cnt_ff,  cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   logic [RW-1:0]  rem_sh;
   logic [RW-1:0]  trial;

   assign rem_sh = {rem_ff[RW-3:0], rad_ff[2*P-1 -: 2]};
   assign trial  = {{(RW-P-2){1'b0}}, root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = {1'b0, radicand, {(2*FRAC_BITS){1'b0}}};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(P - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[2*P-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[P-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[P-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ dv/risk_penalized_route_cost_top_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// risk_penalized_route_cost_top_tb
// Self-checking bench for the risk-penalized tour cost evaluator.
// -----------------------------------------------------------------------------
// A short table of hand-picked stops runs first. Only a few rows carry
// hand-computed costs. After that come random tours under several threshold
// and penalty settings. A local cost model predicts each tour total. Every
// response is checked in order against the oldest pending total. Both
// channels idle and stall at random. Once, the response side holds off for
// a long stretch to back the block up.
// -----------------------------------------------------------------------------
module risk_penalized_route_cost_top_tb;

   localparam int      FRAC         = rpc_pkg::FRAC_BITS_DEF;
   localparam int      COORD_W      = rpc_pkg::COORD_W;
   localparam int      DEMAND_W     = rpc_pkg::DEMAND_W;
   localparam int      COST_W       = rpc_pkg::COST_W;
   localparam int      CSR_IDX_W    = rpc_pkg::CSR_IDX_W;
   localparam int      CSR_DATA_W   = rpc_pkg::CSR_DATA_W;
   localparam int      SETTLE_CYC   = 120;   // > worst request latency (two roots)
   localparam int      IDLE_LIMIT   = 4000;  // covers the long hold plus slack
   localparam int      HOLD_CYC     = 700;
   localparam longint unsigned MONEY_SAT = 64'hFFFF_FFFF;
   localparam longint unsigned RISK_SAT  = 64'hFF_FFFF_FFFF_FFFF;
   localparam longint unsigned COST_SAT  = 64'hFFFF_FFFF_FFFF;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [DEMAND_W-1:0]       demand;
      bit                        ret;
      bit                        last;
   } stop_type;

   typedef struct {
      logic [COST_W-1:0] cost;
      bit                pen;
   } tour_total_type;

   typedef struct {
      stop_type       s;
      bit             typed;    // expected total written in by hand
      tour_total_type want;
   } dir_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_stop_x;
   logic signed [COORD_W-1:0] req_stop_y;
   logic [DEMAND_W-1:0]       req_stop_demand;
   logic                      req_returns_to_depot;
   logic                      req_last_stop;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [COST_W-1:0]         rsp_total_cost;
   logic                      rsp_any_penalty;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   risk_penalized_route_cost_top u_top (.*);

   // cost model state
   longint unsigned thr_reg, pen_reg;
   int              held_x, held_y;
   longint unsigned held_dem;
   bit              leg_open, new_route;
   longint unsigned money, risk, cost;
   bit              pen_flag;

   tour_total_type tour_totals_q[$];
   int             fail_cnt = 0;
   int             totals_seen = 0;
   bit             hold_done = 0;
   bit             stim_done = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned sadd(longint unsigned a, longint unsigned b,
                                            longint unsigned lim);
      longint unsigned s;
      s = a + b;
      if (s < a || s > lim) return lim;
      return s;
   endfunction

   function automatic longint unsigned smul(longint unsigned a, longint unsigned b,
                                            longint unsigned lim);
      if (a == 0 || b == 0) return 0;
      if (a > lim / b) return lim;
      return a * b;
   endfunction

   // floor(sqrt(dx^2+dy^2) * 2^FRAC), built up one result bit at a time
   function automatic longint unsigned leg_len(int dx, int dy);
      longint unsigned v, r, t;
      v = (longint'(dx) * dx + longint'(dy) * dy) << (2 * FRAC);
      r = 0;
      for (int b = 17 + FRAC; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic void charge_leg(longint unsigned d);
      cost = sadd(cost, d, COST_SAT);
      risk = sadd(risk, smul(money, d, RISK_SAT), RISK_SAT);
   endfunction

   function automatic void charge_risk();
      if (risk > thr_reg) begin
         cost     = sadd(cost, smul(money, pen_reg, COST_SAT), COST_SAT);
         pen_flag = 1;
      end
   endfunction

   // advance the model by one stop; returns 1 with the total at a tour end
   function automatic bit predict_stop(stop_type s, output tour_total_type tt);
      int x, y;
      bit ret;
      x   = s.x;
      y   = s.y;
      ret = s.ret | s.last;
      if (leg_open) begin
         charge_leg(leg_len(held_x - x, held_y - y));
         money = sadd(money, held_dem, MONEY_SAT);
         charge_risk();
         leg_open = 0;
      end
      if (new_route) begin
         risk      = 0;
         cost      = sadd(cost, leg_len(x, y), COST_SAT);
         money     = s.demand;
         new_route = 0;
      end
      if (ret) begin
         charge_leg(leg_len(x, y));
         charge_risk();
         new_route = 1;
      end else begin
         held_x   = x;
         held_y   = y;
         held_dem = s.demand;
         leg_open = 1;
      end
      if (!s.last) return 0;
      tt.cost   = cost[COST_W-1:0];
      tt.pen    = pen_flag;
      cost      = 0;
      pen_flag  = 0;
      leg_open  = 0;
      new_route = 1;
      return 1;
   endfunction

   // mostly back-to-back, often short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic stop_type rand_stop(bit ret, bit last);
      stop_type s;
      int       k;
      k = $urandom_range(0, 9);
      if (k < 2) begin
         // corners of the coordinate range
         s.x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         s.y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end else if (k < 5) begin
         s.x = $signed(16'($urandom_range(0, 400) - 200));
         s.y = $signed(16'($urandom_range(0, 400) - 200));
      end else begin
         s.x = $signed(16'($urandom));
         s.y = $signed(16'($urandom));
      end
      k = $urandom_range(0, 9);
      s.demand = (k == 0) ? 16'hFFFF : (k < 3) ? 16'd0 : 16'($urandom);
      s.ret    = ret;
      s.last   = last;
      return s;
   endfunction

   // drive one request and fold it into the model once it is taken
   task automatic send_stop(stop_type s, bit typed, tour_total_type want);
      int             gap;
      tour_total_type tt;
      gap = pick_gap();
      // calm stretches: no sender gaps in the first quarter of each repeating window
      if ($time / 4 % 512 < 128) gap = 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid            <= 1'b1;
      req_stop_x           <= s.x;
      req_stop_y           <= s.y;
      req_stop_demand      <= s.demand;
      req_returns_to_depot <= s.ret;
      req_last_stop        <= s.last;
      do @(posedge clock); while (req_stall);
      if (predict_stop(s, tt))
         tour_totals_q.insert(tour_totals_q.size(), typed ? want : tt);
   endtask

   // sender goes quiet until every total is back and the block has settled
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tour_totals_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == rpc_pkg::CSR_RISK_THRESHOLD) thr_reg = val & RISK_SAT;
      else                                    pen_reg = val & 64'h1FF_FFFF;
   endtask

   // one well-formed tour: routes of random length, last stop may skip the
   // return flag; occasionally pure noise instead
   task automatic random_tour();
      int             n;
      tour_total_type none;
      none = '{cost: '0, pen: 0};
      if ($urandom_range(0, 9) == 0) begin
         send_stop(rand_stop($urandom_range(0, 1), $urandom_range(0, 1)), 0, none);
         return;
      end
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
         send_stop(rand_stop(i == n - 1 ? $urandom_range(0, 1) : ($urandom_range(0, 3) == 0),
                             i == n - 1), 0, none);
   endtask

   // response side: random stall, one long hold once the flow is going,
   // then compare each taken total with the oldest pending one
   initial begin
      int             run;
      tour_total_type want;
      rsp_stall = 1'b1;
      run       = 0;
      forever begin
         @(negedge clock);
         if (!hold_done && totals_seen >= 20) begin
            hold_done = 1;
            run       = HOLD_CYC;
         end
         if (run > 0) begin
            rsp_stall <= 1'b1;
            run--;
         end else if ($time / 4 % 512 >= 384) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 5) == 0) run = pick_gap();
         end
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            totals_seen++;
            if (tour_totals_q.size() == 0) begin
               $error("unexpected response: total_cost=%0d any_penalty=%0b",
                      rsp_total_cost, rsp_any_penalty);
               fail_cnt++;
            end else begin
               want = tour_totals_q.pop_front();
               if (rsp_total_cost !== want.cost) begin
                  $error("total_cost mismatch: expected %0d, got %0d",
                         want.cost, rsp_total_cost);
                  fail_cnt++;
               end
               if (rsp_any_penalty !== want.pen) begin
                  $error("any_penalty mismatch: expected %0b, got %0b",
                         want.pen, rsp_any_penalty);
                  fail_cnt++;
               end
            end
         end
      end
   end

   // watchdog: too long without any handshake on either side
   initial begin
      int idle_cyc;
      idle_cyc = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || stim_done)
            idle_cyc = 0;
         else
            idle_cyc++;
         if (idle_cyc >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      dir_row_type    tab[$];
      tour_total_type none;
      int             wait_cyc;
      none = '{cost: '0, pen: 0};

      req_valid            = 1'b0;
      req_stop_x           = '0;
      req_stop_y           = '0;
      req_stop_demand      = '0;
      req_returns_to_depot = 1'b0;
      req_last_stop        = 1'b0;
      csr_we               = 1'b0;
      csr_index            = rpc_pkg::CSR_RISK_THRESHOLD;
      csr_wdata            = '0;
      reset                = 1'b1;

      thr_reg = 0; pen_reg = 0;
      held_x = 0; held_y = 0; held_dem = 0;
      leg_open = 0; new_route = 1;
      money = 0; risk = 0; cost = 0; pen_flag = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset registers (threshold 0, penalty distance 0)
      // stop at the depot; 3-4-5 out and back; any risk beats zero
      tab.insert(tab.size(), '{'{0, 0, 0, 1, 1}, 1, '{0, 0}});
      tab.insert(tab.size(), '{'{3, 4, 0, 1, 1}, 1, '{2560, 0}});
      tab.insert(tab.size(), '{'{3, 4, 1, 1, 1}, 1, '{2560, 1}});
      tab.insert(tab.size(), '{'{16'sh7FFF, 16'sh7FFF, 16'hFFFF, 0, 0}, 0, none});
      tab.insert(tab.size(), '{'{16'sh8000, 16'sh8000, 16'hFFFF, 0, 0}, 0, none});
      tab.insert(tab.size(), '{'{16'sh8000, 16'sh7FFF, 0, 1, 0}, 0, none});
      // last, no return
      tab.insert(tab.size(), '{'{16'sh7FFF, 16'sh8000, 16'hFFFF, 0, 1}, 0, none});
      tab.insert(tab.size(), '{'{0, 0, 16'hFFFF, 0, 0}, 0, none});
      tab.insert(tab.size(), '{'{0, 0, 16'hFFFF, 0, 0}, 0, none});
      tab.insert(tab.size(), '{'{0, 0, 16'hFFFF, 1, 0}, 0, none});
      tab.insert(tab.size(), '{'{100, -100, 7, 0, 1}, 0, none});
      tab.insert(tab.size(), '{'{-1, -1, 1, 1, 1}, 0, none});
      tab.insert(tab.size(), '{'{-5, 12, 300, 0, 0}, 0, none});
      tab.insert(tab.size(), '{'{5, -12, 300, 1, 1}, 0, none});
      foreach (tab[i]) send_stop(tab[i].s, tab[i].typed, tab[i].want);
      drain();

      // extremes: nothing ever crosses the threshold, and the largest charge
      csr_write(rpc_pkg::CSR_RISK_THRESHOLD, 56'hFF_FFFF_FFFF_FFFF);
      csr_write(rpc_pkg::CSR_PENALTY_DISTANCE, 56'h1FF_FFFF);
      tab.delete();
      tab.insert(tab.size(), '{'{16'sh7FFF, 16'sh7FFF, 16'hFFFF, 0, 0}, 0, none});
      tab.insert(tab.size(), '{'{16'sh8000, 16'sh8000, 16'hFFFF, 0, 1}, 0, none});
      foreach (tab[i]) send_stop(tab[i].s, tab[i].typed, tab[i].want);
      while (totals_seen < 1000 && tab.size() < 40) begin
         random_tour();
         void'(tab.pop_front());
         if (tab.size() == 0) break;
      end
      for (int i = 0; i < 20; i++) random_tour();
      drain();

      // zero threshold with full penalty: routes with any risk pay, cost can saturate
      csr_write(rpc_pkg::CSR_RISK_THRESHOLD, '0);
      for (int i = 0; i < 20; i++) random_tour();
      drain();

      // mid settings, then random ones
      csr_write(rpc_pkg::CSR_RISK_THRESHOLD, 56'd1 << 30);
      csr_write(rpc_pkg::CSR_PENALTY_DISTANCE, 56'd256);
      for (int i = 0; i < 20; i++) random_tour();
      drain();
      repeat (2) begin
         csr_write(rpc_pkg::CSR_RISK_THRESHOLD,
                   {24'($urandom_range(0, 255)), 32'($urandom)});
         csr_write(rpc_pkg::CSR_PENALTY_DISTANCE, 56'($urandom_range(0, 33554431)));
         for (int i = 0; i < 15; i++) random_tour();
         drain();
      end

      // closing: wait for the last totals, with a bound
      stim_done = 1;
      wait_cyc  = 0;
      while (tour_totals_q.size() != 0 && wait_cyc < IDLE_LIMIT) begin
         @(posedge clock);
         wait_cyc++;
      end
      repeat (SETTLE_CYC) @(posedge clock);
      if (fail_cnt == 0 && tour_totals_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
